// ===== src/prts_pkg.sv =====
package prts_pkg;

    // Field widths
    localparam int COORD_BITS  = 16;
    localparam int ANGLE_BITS  = 12;
    localparam int FACTOR_BITS = 16;

    // Quarter-wave sine table geometry
    localparam int QTR_SHIFT = ANGLE_BITS - 2;
    localparam int QTR_SIZE  = 1 << QTR_SHIFT;
    localparam int IDX_BITS  = QTR_SHIFT + 1;

    // Trig values: Q1.15 magnitude up to exactly 1.0, plus sign
    localparam int MAG_BITS    = 17;
    localparam int TRIG_BITS   = MAG_BITS + 1;
    localparam int TRIG_FRAC   = 15;
    localparam int FACTOR_FRAC = 8;

    // Working width for the sums ahead of saturation
    localparam int WIDE_BITS = COORD_BITS + TRIG_BITS + 2;

    // pi/2 in Q2.30
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef enum logic [1:0] {
        ACT_LOAD      = 2'd0,
        ACT_TRANSLATE = 2'd1,
        ACT_ROTATE    = 2'd2,
        ACT_SCALE     = 2'd3
    } t_action;

    typedef logic signed [COORD_BITS-1:0]  t_coord;
    typedef logic signed [TRIG_BITS-1:0]   t_trig;
    typedef logic signed [FACTOR_BITS-1:0] t_factor;
    typedef logic signed [WIDE_BITS-1:0]   t_wide;
    typedef logic [MAG_BITS-1:0]           t_mag;
    typedef t_mag                          t_sin_tab [0:QTR_SIZE];

    // Input transaction
    typedef struct packed {
        t_action               action;
        t_coord                arg_x;
        t_coord                arg_y;
        logic [ANGLE_BITS-1:0] angle;
        t_factor               factor;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        t_coord point_x_out;
        t_coord point_y_out;
    } t_out_item;

    // Registered operands with trig values already looked up
    typedef struct packed {
        t_action action;
        t_coord  arg_x;
        t_coord  arg_y;
        t_factor factor;
        t_trig   sin_val;
        t_trig   cos_val;
    } t_prep;

    // Quarter-wave entry k: truncating Taylor series in Q2.30, rounded to Q1.15.
    // Evaluated only at elaboration to build the table.
    function automatic t_mag f_qtr_sine(input int k);
        longint t;
        longint t2;
        longint term;
        longint sum;
        t    = (HALF_PI_Q30 * longint'(k)) >>> QTR_SHIFT;
        t2   = (t * t) >>> 30;
        term = t;
        sum  = t;
        // Terms t^3 through t^13; divisors are (2n)(2n+1), signs alternate
        term = ((term * t2) >>> 30) / 64'sd6;
        sum  = sum - term;
        term = ((term * t2) >>> 30) / 64'sd20;
        sum  = sum + term;
        term = ((term * t2) >>> 30) / 64'sd42;
        sum  = sum - term;
        term = ((term * t2) >>> 30) / 64'sd72;
        sum  = sum + term;
        term = ((term * t2) >>> 30) / 64'sd110;
        sum  = sum - term;
        term = ((term * t2) >>> 30) / 64'sd156;
        sum  = sum + term;
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum + (64'sd1 <<< 14)) >>> 15;
        if (sum > 64'sd32768) begin
            sum = 64'sd32768;
        end
        return MAG_BITS'(sum);
    endfunction

    function automatic t_sin_tab f_build_sin_tab();
        t_sin_tab tab;
        int       k;
        for (k = 0; k <= QTR_SIZE; k++) begin
            tab[k] = f_qtr_sine(k);
        end
        return tab;
    endfunction

    localparam t_sin_tab SIN_TAB = f_build_sin_tab();

    // Signed sine of a binary angle, folded from the quarter-wave table
    function automatic t_trig f_sine(input logic [ANGLE_BITS-1:0] a);
        logic [1:0]          q;
        logic [IDX_BITS-1:0] r;
        logic [IDX_BITS-1:0] idx;
        t_trig               mag;
        q   = a[ANGLE_BITS-1 -: 2];
        r   = {1'b0, a[QTR_SHIFT-1:0]};
        idx = q[0] ? (IDX_BITS'(QTR_SIZE) - r) : r;
        mag = $signed({1'b0, SIN_TAB[idx]});
        return q[1] ? -mag : mag;
    endfunction

    // Arithmetic shift right that truncates toward zero, like a C division
    function automatic t_wide f_div_pow2(input t_wide v, input int sh);
        t_wide bias;
        bias = v[WIDE_BITS-1] ? ((t_wide'(1) <<< sh) - t_wide'(1)) : '0;
        return (v + bias) >>> sh;
    endfunction

    // Clamp to the signed coordinate range
    function automatic t_coord f_sat(input t_wide v);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (COORD_BITS - 1)) - t_wide'(1);
        lo = -hi - t_wide'(1);
        if (v > hi) begin
            return {1'b0, {(COORD_BITS - 1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(COORD_BITS - 1){1'b0}}};
        end
        return v[COORD_BITS-1:0];
    endfunction

endpackage

// ===== src/prts_core.sv =====
// Next-point datapath: one action applied to the current point
module prts_core (
    input  prts_pkg::t_prep     i_prep,
    input  prts_pkg::t_coord    i_cur_x,
    input  prts_pkg::t_coord    i_cur_y,
    output prts_pkg::t_out_item o_next
);

    logic signed [prts_pkg::COORD_BITS:0] dx;
    logic signed [prts_pkg::COORD_BITS:0] dy;

    // Rotation partial products
    logic signed [prts_pkg::COORD_BITS+prts_pkg::TRIG_BITS:0] p_xc;
    logic signed [prts_pkg::COORD_BITS+prts_pkg::TRIG_BITS:0] p_ys;
    logic signed [prts_pkg::COORD_BITS+prts_pkg::TRIG_BITS:0] p_yc;
    logic signed [prts_pkg::COORD_BITS+prts_pkg::TRIG_BITS:0] p_xs;

    // Scale products
    logic signed [prts_pkg::COORD_BITS+prts_pkg::FACTOR_BITS:0] p_xf;
    logic signed [prts_pkg::COORD_BITS+prts_pkg::FACTOR_BITS:0] p_yf;

    prts_pkg::t_wide ax_w;
    prts_pkg::t_wide ay_w;
    prts_pkg::t_wide rot_x;
    prts_pkg::t_wide rot_y;
    prts_pkg::t_wide scl_x;
    prts_pkg::t_wide scl_y;
    prts_pkg::t_wide trn_x;
    prts_pkg::t_wide trn_y;
    prts_pkg::t_wide nx;
    prts_pkg::t_wide ny;

    // Offsets from center / anchor
    assign dx = $signed({i_cur_x[prts_pkg::COORD_BITS-1], i_cur_x})
              - $signed({i_prep.arg_x[prts_pkg::COORD_BITS-1], i_prep.arg_x});
    assign dy = $signed({i_cur_y[prts_pkg::COORD_BITS-1], i_cur_y})
              - $signed({i_prep.arg_y[prts_pkg::COORD_BITS-1], i_prep.arg_y});

    assign ax_w = prts_pkg::t_wide'(i_prep.arg_x);
    assign ay_w = prts_pkg::t_wide'(i_prep.arg_y);

    // Multipliers
    assign p_xc = dx * i_prep.cos_val;
    assign p_ys = dy * i_prep.sin_val;
    assign p_yc = dy * i_prep.cos_val;
    assign p_xs = dx * i_prep.sin_val;
    assign p_xf = dx * i_prep.factor;
    assign p_yf = dy * i_prep.factor;

    // Rotate: Q1.15 product back to integer, truncated toward zero
    assign rot_x = prts_pkg::f_div_pow2(prts_pkg::t_wide'(p_xc) - prts_pkg::t_wide'(p_ys),
                                        prts_pkg::TRIG_FRAC) + ax_w;
    assign rot_y = prts_pkg::f_div_pow2(prts_pkg::t_wide'(p_yc) + prts_pkg::t_wide'(p_xs),
                                        prts_pkg::TRIG_FRAC) + ay_w;

    // Scale: Q8.8 factor, truncated toward zero
    assign scl_x = prts_pkg::f_div_pow2(prts_pkg::t_wide'(p_xf), prts_pkg::FACTOR_FRAC) + ax_w;
    assign scl_y = prts_pkg::f_div_pow2(prts_pkg::t_wide'(p_yf), prts_pkg::FACTOR_FRAC) + ay_w;

    // Translate
    assign trn_x = prts_pkg::t_wide'(i_cur_x) + ax_w;
    assign trn_y = prts_pkg::t_wide'(i_cur_y) + ay_w;

    // Action select
    always_comb begin
        case (i_prep.action)
            prts_pkg::ACT_LOAD: begin
                nx = ax_w;
                ny = ay_w;
            end
            prts_pkg::ACT_TRANSLATE: begin
                nx = trn_x;
                ny = trn_y;
            end
            prts_pkg::ACT_ROTATE: begin
                nx = rot_x;
                ny = rot_y;
            end
            prts_pkg::ACT_SCALE: begin
                nx = scl_x;
                ny = scl_y;
            end
            default: begin
                nx = ax_w;
                ny = ay_w;
            end
        endcase
    end

    assign o_next.point_x_out = prts_pkg::f_sat(nx);
    assign o_next.point_y_out = prts_pkg::f_sat(ny);

endmodule

// ===== src/point_rotate_translate_scale_unit.sv =====
// Channel   Direction  Handshake             Payload
// input     in         i_valid / o_stall     i_item (t_in_item)
// result    out        o_valid / i_stall     o_item (t_out_item)
//
// One transaction per cycle sustained while the result side does not stall. An
// accepted input is registered twice: the trig table is read into the operand
// register, then the multiply / add / saturate path feeds the result register.
// The result register also holds the current point; reset sets it to (0, 0).
// A stall on the result side holds a waiting result and the operand behind it;
// the input side stalls only when the operand register is full and cannot move on.
module point_rotate_translate_scale_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  prts_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output prts_pkg::t_out_item o_item
);

    logic                r_in_valid;
    prts_pkg::t_prep     r_prep;
    prts_pkg::t_prep     n_prep;
    logic                r_out_valid;
    prts_pkg::t_out_item r_out;
    prts_pkg::t_out_item n_out;
    logic                advance;
    logic                in_ready;

    // Pipeline flow control
    assign advance  = r_in_valid & (~r_out_valid | ~i_stall);
    assign in_ready = ~r_in_valid | advance;
    assign o_stall  = ~in_ready;

    // Operand stage: look up sine and cosine at accept
    always_comb begin
        n_prep.action  = i_item.action;
        n_prep.arg_x   = i_item.arg_x;
        n_prep.arg_y   = i_item.arg_y;
        n_prep.factor  = i_item.factor;
        n_prep.sin_val = prts_pkg::f_sine(i_item.angle);
        n_prep.cos_val = prts_pkg::f_sine(i_item.angle
                                          + prts_pkg::ANGLE_BITS'(prts_pkg::QTR_SIZE));
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_prep <= n_prep;
        end
    end

    // Datapath against the current point
    prts_core u_core (
        .i_prep  (r_prep),
        .i_cur_x (r_out.point_x_out),
        .i_cur_y (r_out.point_y_out),
        .o_next  (n_out)
    );

    // Valid bits and the point / result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule
